// ===== rtl/assert_macros.svh =====
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge outside reset.
`define DCLP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check on every clock edge, reset included.
`define DCLP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== rtl/dclp_pkg.sv =====
package dclp_pkg;

  typedef enum logic [2:0] {
    TK_CMD_BYTE  = 3'd0,
    TK_CMD_END   = 3'd1,
    TK_KEY       = 3'd2,
    TK_VAL_BYTE  = 3'd3,
    TK_VAL_DONE  = 3'd4,
    TK_PARSE_ERR = 3'd5,
    TK_DUP       = 3'd6,
    TK_LINE_DONE = 3'd7
  } tok_kind_e;

  typedef enum logic [8:0] {
    PH_CMD     = 9'b000000001,
    PH_NORMAL  = 9'b000000010,
    PH_OPT     = 9'b000000100,
    PH_SEP     = 9'b000001000,
    PH_FIRST   = 9'b000010000,
    PH_PLAIN   = 9'b000100000,
    PH_QUOTED  = 9'b001000000,
    PH_SKIP    = 9'b010000000,
    PH_DISCARD = 9'b100000000
  } phase_e;

  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam int unsigned QueueDepth = 4;

  typedef struct packed {
    tok_kind_e   kind;
    logic [7:0]  data;
    logic        last;
  } token_t;

  // Up to two tokens produced by one byte, in order.
  typedef struct packed {
    logic [1:0]        cnt;
    token_t [1:0]      tok;
  } tok_pair_t;

endpackage

// ===== rtl/dclp_parse.sv =====
module dclp_parse import dclp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       fire_i,
  input  logic [7:0] char_i,
  output tok_pair_t  pair_o
);

  phase_e       phase_q, phase_d;
  logic         esc_q, esc_d;
  logic [7:0]   key_q, key_d;
  logic         cmd_ne_q, cmd_ne_d;
  logic [255:0] seen_q;

  logic         is_end, key_dash, dup, seen_set;
  logic         have_a;
  tok_kind_e    kind_a;
  logic [7:0]   data_a;

  assign is_end   = (char_i == 8'h00);
  assign key_dash = (key_q == CH_DASH);
  assign dup      = seen_q[key_q];

  always_comb begin
    phase_d  = phase_q;
    esc_d    = esc_q;
    key_d    = key_q;
    cmd_ne_d = cmd_ne_q;
    seen_set = 1'b0;
    have_a   = 1'b0;
    kind_a   = TK_CMD_BYTE;
    data_a   = 8'h00;
    case (phase_q)
      PH_CMD: begin
        have_a = 1'b1;
        if (is_end) begin
          kind_a = cmd_ne_q ? TK_CMD_END : TK_PARSE_ERR;
        end else if (char_i == CH_SPACE) begin
          kind_a  = TK_CMD_END;
          phase_d = PH_NORMAL;
        end else begin
          kind_a   = TK_CMD_BYTE;
          data_a   = char_i;
          cmd_ne_d = 1'b1;
        end
      end
      PH_NORMAL: begin
        if (char_i != CH_DASH) begin
          have_a  = 1'b1;
          kind_a  = TK_PARSE_ERR;
          phase_d = PH_DISCARD;
        end else begin
          phase_d = PH_OPT;
        end
      end
      PH_OPT: begin
        if (!is_end) begin
          have_a  = 1'b1;
          kind_a  = TK_KEY;
          data_a  = char_i;
          key_d   = char_i;
          phase_d = PH_SEP;
        end
      end
      PH_SEP: begin
        if (char_i != CH_SPACE) begin
          have_a  = 1'b1;
          kind_a  = TK_PARSE_ERR;
          phase_d = PH_DISCARD;
        end else begin
          phase_d = PH_FIRST;
        end
      end
      PH_FIRST: begin
        if (!is_end) begin
          if (char_i == CH_QUOTE && !key_dash) begin
            phase_d = PH_QUOTED;
          end else begin
            have_a  = 1'b1;
            kind_a  = TK_VAL_BYTE;
            data_a  = char_i;
            phase_d = PH_PLAIN;
          end
        end
      end
      PH_PLAIN: begin
        have_a = 1'b1;
        if (is_end || (char_i == CH_SPACE && !key_dash)) begin
          if (dup) begin
            kind_a  = TK_DUP;
            phase_d = PH_DISCARD;
          end else begin
            kind_a   = TK_VAL_DONE;
            seen_set = 1'b1;
            phase_d  = PH_NORMAL;
          end
        end else begin
          kind_a = TK_VAL_BYTE;
          data_a = char_i;
        end
      end
      PH_QUOTED: begin
        if (!is_end) begin
          have_a = 1'b1;
          kind_a = TK_VAL_BYTE;
          data_a = char_i;
          if (char_i == CH_BSL) begin
            esc_d = !esc_q;
          end else if (char_i == CH_QUOTE) begin
            if (esc_q) begin
              esc_d = 1'b0;
            end else begin
              data_a = 8'h00;
              if (dup) begin
                kind_a  = TK_DUP;
                phase_d = PH_DISCARD;
              end else begin
                kind_a   = TK_VAL_DONE;
                seen_set = 1'b1;
                phase_d  = PH_SKIP;
              end
            end
          end
        end
      end
      PH_SKIP: begin
        phase_d = PH_NORMAL;
      end
      default: begin
      end
    endcase
    // line end: back to a fresh line
    if (is_end) begin
      phase_d  = PH_CMD;
      esc_d    = 1'b0;
      key_d    = 8'h00;
      cmd_ne_d = 1'b0;
    end
  end

  always_comb begin
    pair_o        = '0;
    pair_o.tok[0] = '{kind: kind_a, data: data_a, last: !is_end};
    pair_o.tok[1] = '{kind: TK_LINE_DONE, data: 8'h00, last: 1'b1};
    if (is_end && !have_a) begin
      pair_o.tok[0] = '{kind: TK_LINE_DONE, data: 8'h00, last: 1'b1};
    end
    if (fire_i) begin
      pair_o.cnt = {1'b0, have_a} + {1'b0, is_end};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_CMD;
      esc_q    <= 1'b0;
      key_q    <= 8'h00;
      cmd_ne_q <= 1'b0;
      seen_q   <= '0;
    end else if (fire_i) begin
      phase_q  <= phase_d;
      esc_q    <= esc_d;
      key_q    <= key_d;
      cmd_ne_q <= cmd_ne_d;
      if (is_end) begin
        seen_q <= '0;
      end else if (seen_set) begin
        seen_q[key_q] <= 1'b1;
      end
    end
  end

endmodule

// ===== rtl/dclp_outq.sv =====
module dclp_outq import dclp_pkg::*; #(
  parameter int unsigned Depth = QueueDepth
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  tok_pair_t pair_i,
  output logic      room_o,
  output logic      valid_o,
  input  logic      ready_i,
  output token_t    tok_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  token_t            mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q, wr_ptr_1;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              pop;

  assign valid_o  = (cnt_q != '0);
  assign tok_o    = mem_q[rd_ptr_q];
  assign pop      = valid_o && ready_i;
  // keep room for the two beats a line end can bring
  assign room_o   = (cnt_q <= CntW'(Depth - 2));
  assign wr_ptr_1 = wr_ptr_q + PtrW'(1);
  assign cnt_d    = cnt_q + CntW'(pair_i.cnt) - CntW'(pop);

  always_ff @(posedge clk_i) begin
    if (pair_i.cnt != 2'd0) begin
      mem_q[wr_ptr_q] <= pair_i.tok[0];
    end
    if (pair_i.cnt == 2'd2) begin
      mem_q[wr_ptr_1] <= pair_i.tok[1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + PtrW'(pair_i.cnt);
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      cnt_q <= cnt_d;
    end
  end

endmodule

// ===== rtl/debug_command_line_parser_core.sv =====
// Streaming command line parser: takes one byte per cycle on the input channel
// and emits command, key and value tokens plus error and line-done markers on
// the output channel. A byte is registered at acceptance, parsed once the
// queue has room and its tokens written into a four-entry token queue, so
// the first token passes the input register and the queue before it appears.
// The sustained rate is one byte per cycle while the queue has room; a zero
// byte adds a line-done beat, so a line of N bytes yields up to N+1 output
// beats, and the queue pauses input only while it holds more than two beats.
// The seen-key map is a 256-bit register cleared at reset and every line end.
module debug_command_line_parser_core import dclp_pkg::*; #(
  parameter int unsigned QDepth = QueueDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] char_in_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [2:0] token_kind_o,
  output logic [7:0] token_byte_o,
  output logic       last_of_run_o
);

  logic       in_vld_q;
  logic [7:0] char_q;
  logic       room, fire;
  tok_pair_t  pair;
  token_t     tok;

  assign fire       = in_vld_q && room;
  assign in_ready_o = !in_vld_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      in_vld_q <= 1'b1;
    end else if (fire) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      char_q <= char_in_i;
    end
  end

  dclp_parse u_parse (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .char_i (char_q),
    .pair_o (pair)
  );

  dclp_outq #(
    .Depth (QDepth)
  ) u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .pair_i  (pair),
    .room_o  (room),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .tok_o   (tok)
  );

  assign token_kind_o  = tok.kind;
  assign token_byte_o  = tok.data;
  assign last_of_run_o = tok.last;

endmodule

// ===== rtl/dclp_checker.sv =====
`include "assert_macros.svh"

module dclp_checker import dclp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       out_valid_i,
  input  logic       out_ready_i,
  input  logic [2:0] token_kind_i,
  input  logic [7:0] token_byte_i,
  input  logic       last_of_run_i
);

  logic        stall, beat, marker;
  logic [11:0] beat_bits;

  assign stall     = out_valid_i && !out_ready_i;
  assign beat      = out_valid_i && out_ready_i;
  assign beat_bits = {token_kind_i, token_byte_i, last_of_run_i};
  assign marker    = out_valid_i && token_kind_i != TK_CMD_BYTE && token_kind_i != TK_KEY &&
                     token_kind_i != TK_VAL_BYTE;

  // a stalled beat holds
  `DCLP_ASSERT(a_out_hold, stall |=> out_valid_i && $stable(beat_bits), "beat changed while stalled")

  // the queue is empty from the edge after reset is seen
  `DCLP_ASSERT_ALWAYS(a_rst_quiet, !rst_ni |=> !out_valid_i, "output valid after reset")

  `DCLP_ASSERT(a_line_done_last, out_valid_i && token_kind_i == TK_LINE_DONE |-> last_of_run_i, "line done not marked last")

  `DCLP_ASSERT(a_run_continues, beat && !last_of_run_i |=> out_valid_i, "run broken after a non-last beat")

  `DCLP_ASSERT(a_byte_zero, marker |-> token_byte_i == 8'h00, "byte set on a marker token")

endmodule

bind debug_command_line_parser_core dclp_checker u_dclp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .token_kind_i  (token_kind_o),
  .token_byte_i  (token_byte_o),
  .last_of_run_i (last_of_run_o)
);
